>>> rtl/olar_pkg.sv
// ----------------------------------------------------------------------------
// olar_pkg
// Shared types and constants for the ordered list append/remove unit.
// ----------------------------------------------------------------------------
package olar_pkg;

  // Default number of entries the list can hold.
  localparam int unsigned CAPACITY_DEF = 16;

  // Fixed field widths of the item and result payloads.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;

  // Operation carried from the front end to the back end.
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Completion status reported with every result of a dump.
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  // Decoded command held in the queue between front and back.
  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } cmd_t;

  // One result item of a list dump.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          index;
    logic                      last;
    logic                      empty;
    status_e                   status;
  } res_t;

endpackage

>>> rtl/olar_ram.sv
// ----------------------------------------------------------------------------
// olar_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module olar_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port; storage has no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data appears the cycle after the read enable.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/olar_front.sv
// ----------------------------------------------------------------------------
// olar_front
// Input side: accepts items, decodes the operation and queues the command.
// ----------------------------------------------------------------------------
module olar_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic signed [olar_pkg::VALUE_W-1:0] value_i,
  input  logic [olar_pkg::POS_W-1:0]          position_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output olar_pkg::cmd_t                      cmd_o
);

  import olar_pkg::*;

  cmd_t head_q, skid_q;
  logic head_v_q, skid_v_q;
  cmd_t decoded;
  logic push, pop;

  // Classify the incoming item into a command.
  always_comb begin
    decoded.op       = mode_i ? OP_REMOVE : OP_APPEND;
    decoded.value    = value_i;
    decoded.position = position_i;
  end

  assign in_ready_o  = ~skid_v_q;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = head_v_q & cmd_ready_i;
  assign cmd_valid_o = head_v_q;
  assign cmd_o       = head_q;

  // Two-entry command queue: head register plus one behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop && skid_v_q) begin
      head_v_q <= 1'b1;
      skid_v_q <= push;
    end else if (pop) begin
      head_v_q <= push;
    end else if (push) begin
      if (!head_v_q) begin
        head_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // Payload side of the queue.
  always_ff @(posedge clk_i) begin
    if (pop && skid_v_q) begin
      head_q <= skid_q;
      if (push) begin
        skid_q <= decoded;
      end
    end else if (pop) begin
      if (push) begin
        head_q <= decoded;
      end
    end else if (push) begin
      if (!head_v_q) begin
        head_q <= decoded;
      end else begin
        skid_q <= decoded;
      end
    end
  end

endmodule

>>> rtl/olar_back.sv
// ----------------------------------------------------------------------------
// olar_back
// Execution side: owns the entry store, carries out append and removal, and
// streams the list out through a two-entry result buffer.
// ----------------------------------------------------------------------------
module olar_back #(
  parameter int unsigned Capacity = olar_pkg::CAPACITY_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  olar_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output olar_pkg::res_t res_o
);

  import olar_pkg::*;

  localparam int unsigned AW   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_DUMP
  } state_e;

  state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] src_q, src_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          wpend_q, wpend_d;
  logic [AW-1:0] idx_q, idx_d;
  status_e       stat_q, stat_d;
  logic          pend_q, pend_d;
  res_t          pend_res_q, pend_res_d;

  res_t head_q, skid_q, push_res;
  logic head_v_q, skid_v_q;
  logic push, pop, slot_ok, is_last;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;
  logic [CMPW-1:0]    pos_ext, cnt_ext;

  olar_ram #(
    .Width(VALUE_W),
    .Depth(Capacity)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result buffer bookkeeping: a read may only be issued when its data is
  // sure to find room the cycle it returns.
  assign pop     = head_v_q & out_ready_i;
  assign slot_ok = (2'(head_v_q) + 2'(skid_v_q) + 2'(pend_q)) <= (2'd1 + 2'(pop));
  assign pos_ext = CMPW'(cmd_i.position);
  assign cnt_ext = CMPW'(count_q);
  assign is_last = (CW'(idx_q) + CW'(1)) == count_q;

  // Sequencer for the current command.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    src_d       = src_q;
    wr_addr_d   = wr_addr_q;
    wpend_d     = wpend_q;
    idx_d       = idx_q;
    stat_d      = stat_q;
    pend_d      = 1'b0;
    pend_res_d  = pend_res_q;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          idx_d = '0;
          case (cmd_i.op)
            OP_APPEND: begin
              state_d = S_DUMP;
              if (count_q == CW'(Capacity)) begin
                stat_d = ST_FULL;
              end else begin
                stat_d    = ST_DONE;
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = cmd_i.value;
                count_d   = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (pos_ext >= cnt_ext) begin
                stat_d  = ST_BADPOS;
                state_d = S_DUMP;
              end else begin
                stat_d  = ST_DONE;
                src_d   = CW'(pos_ext) + CW'(1);
                wpend_d = 1'b0;
                state_d = S_SHIFT;
              end
            end
            default: begin
              stat_d  = ST_DONE;
              state_d = S_DUMP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Read the entry above, write it one place down the next cycle.
        if (wpend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr_q;
          ram_wdata = ram_rdata;
        end
        if (src_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = src_q[AW-1:0];
          src_d     = src_q + CW'(1);
          wr_addr_d = AW'(src_q - CW'(1));
          wpend_d   = 1'b1;
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            count_d = count_q - CW'(1);
            state_d = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (slot_ok) begin
          pend_d = 1'b1;
          if (count_q == '0) begin
            pend_res_d.value  = '0;
            pend_res_d.index  = '0;
            pend_res_d.last   = 1'b1;
            pend_res_d.empty  = 1'b1;
            pend_res_d.status = stat_q;
            state_d           = S_IDLE;
          end else begin
            ram_re            = 1'b1;
            ram_raddr         = idx_q;
            pend_res_d.value  = '0;
            pend_res_d.index  = POS_W'(idx_q);
            pend_res_d.last   = is_last;
            pend_res_d.empty  = 1'b0;
            pend_res_d.status = stat_q;
            idx_d             = idx_q + AW'(1);
            if (is_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Returning read data joins its result fields.
  assign push = pend_q;
  always_comb begin
    push_res       = pend_res_q;
    push_res.value = pend_res_q.empty ? pend_res_q.value : ram_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      wpend_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wpend_q <= wpend_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers that need no reset.
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    wr_addr_q  <= wr_addr_d;
    idx_q      <= idx_d;
    stat_q     <= stat_d;
    pend_res_q <= pend_res_d;
  end

  // Two-entry result buffer, valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop && skid_v_q) begin
      head_v_q <= 1'b1;
      skid_v_q <= push;
    end else if (pop) begin
      head_v_q <= push;
    end else if (push) begin
      if (!head_v_q) begin
        head_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk_i) begin
    if (pop && skid_v_q) begin
      head_q <= skid_q;
      if (push) begin
        skid_q <= push_res;
      end
    end else if (pop) begin
      if (push) begin
        head_q <= push_res;
      end
    end else if (push) begin
      if (!head_v_q) begin
        head_q <= push_res;
      end else begin
        skid_q <= push_res;
      end
    end
  end

  assign out_valid_o = head_v_q;
  assign res_o       = head_q;

endmodule

>>> rtl/ordered_list_append_remove_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_append_remove_unit
// Bounded ordered list of signed 32-bit values with append and remove.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid_i/in_ready_o) either
// appends value_i at the tail (mode_i = 0) or removes the entry at
// position_i (mode_i = 1). After every operation the whole list leaves on
// the output channel (out_valid_o/out_ready_i), one transfer per entry in
// order, the final one with last_entry_o set; an empty list gives a single
// transfer with list_empty_o set. Every transfer of one dump carries the
// operation's status_o.
// Timing: the execution side takes each command, then reads out one result
// per entry. A removal first moves the entries above the gap down one place
// per cycle, from the gap up to the tail, before its dump begins.
// Reset clears the list length; the store itself is not cleared, and no
// clearing pass is needed. When the receiver stalls, a two-entry result
// buffer fills and the store reads pause; new items are still queued until
// the two-entry command queue fills.
module ordered_list_append_remove_unit #(
  parameter int unsigned Capacity = olar_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic signed [olar_pkg::VALUE_W-1:0] value_i,
  input  logic [olar_pkg::POS_W-1:0]          position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [olar_pkg::VALUE_W-1:0] entry_value_o,
  output logic [olar_pkg::POS_W-1:0]          entry_index_o,
  output logic                                last_entry_o,
  output logic                                list_empty_o,
  output logic [1:0]                          status_o
);

  import olar_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  // Front end: accept and decode.
  olar_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .position_i (position_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // Back end: update the store and dump the list.
  olar_back #(
    .Capacity(Capacity)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res)
  );

  assign entry_value_o = res.value;
  assign entry_index_o = res.index;
  assign last_entry_o  = res.last;
  assign list_empty_o  = res.empty;
  assign status_o      = res.status;

endmodule

>>> rtl/olar_checker.sv
// ----------------------------------------------------------------------------
// olar_checker
// Port-level checks for the ordered list unit, bound to the top level.
// ----------------------------------------------------------------------------
module olar_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                mode_i,
  input logic signed [olar_pkg::VALUE_W-1:0] value_i,
  input logic [olar_pkg::POS_W-1:0]          position_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [olar_pkg::VALUE_W-1:0] entry_value_o,
  input logic [olar_pkg::POS_W-1:0]          entry_index_o,
  input logic                                last_entry_o,
  input logic                                list_empty_o,
  input logic [1:0]                          status_o
);

  import olar_pkg::*;

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_value_o) &&
      $stable(entry_index_o) && $stable(last_entry_o) && $stable(status_o))
    else $error("stalled result changed");

  // An empty-list result is the only and final result of its dump.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_empty_o |->
      last_entry_o && entry_index_o == '0 && entry_value_o == '0)
    else $error("empty-list result malformed");

  // Only defined status codes are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_DONE || status_o == ST_FULL ||
      status_o == ST_BADPOS)
    else $error("undefined status code");

  // A dump that carries entries starts at index zero after a final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_entry_o ##1 out_valid_o && !list_empty_o
      |-> entry_index_o == '0)
    else $error("dump does not start at the head of the list");

endmodule

bind ordered_list_append_remove_unit olar_checker u_olar_checker (.*);

>>> verif/ordered_list_append_remove_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_append_remove_unit_test
// Self-checking bench for the ordered list append/remove unit.
// ----------------------------------------------------------------------------
// A queue of list operations is built up front: a short directed run covering
// the value extremes, removal from an empty list, filling to capacity, a
// dropped append and removal past the end, then random runs that steer the
// list between nearly empty and full. A clocked driver presents them on the
// input channel and a clocked monitor checks every transfer of each list dump
// against a shadow copy of the list kept in the bench. Both channels idle at
// random in the first two of three phases and not in the third, and the
// sender at times holds off until every outstanding dump has been drained.
// ----------------------------------------------------------------------------
module ordered_list_append_remove_unit_test;
  import olar_pkg::*;

  localparam int unsigned ListDepth  = CAPACITY_DEF;
  localparam int unsigned RandomOps  = 457;
  localparam int unsigned DrainCycles = ListDepth + 8;

  // One pending list operation, tagged with its idling phase.
  typedef struct {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    int unsigned               phase;
    bit                        hold;
  } list_op_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      mode_i;
  logic signed [VALUE_W-1:0] value_i;
  logic [POS_W-1:0]          position_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [VALUE_W-1:0] entry_value_o;
  logic [POS_W-1:0]          entry_index_o;
  logic                      last_entry_o;
  logic                      list_empty_o;
  logic [1:0]                status_o;

  list_op_t                  op_backlog[$];
  res_t                      dump_expect[$];
  logic signed [VALUE_W-1:0] list_shadow[$];
  int unsigned               error_count;
  int unsigned               send_idle_pct;
  int unsigned               recv_idle_pct;
  logic                      in_taken;

  ordered_list_append_remove_unit #(
    .Capacity(ListDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .entry_value_o(entry_value_o),
    .entry_index_o(entry_index_o),
    .last_entry_o (last_entry_o),
    .list_empty_o (list_empty_o),
    .status_o     (status_o)
  );

  // Clock generation, 10 ns period.
  always #5 clk_i = ~clk_i;

  // Apply an operation to the shadow list and queue the dump it produces.
  task automatic predict_dump(input op_e op, input logic signed [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    status_e st;
    res_t    r;
    st = ST_DONE;
    if (op == OP_APPEND) begin
      if (list_shadow.size() >= ListDepth) st = ST_FULL;
      else list_shadow.push_back(val);
    end else begin
      if (int'(pos) >= list_shadow.size()) st = ST_BADPOS;
      else list_shadow.delete(int'(pos));
    end
    if (list_shadow.size() == 0) begin
      r = '{value: '0, index: '0, last: 1'b1, empty: 1'b1, status: st};
      dump_expect.push_back(r);
    end else begin
      for (int i = 0; i < list_shadow.size(); i++) begin
        r.value  = list_shadow[i];
        r.index  = POS_W'(i);
        r.last   = (i + 1 == list_shadow.size());
        r.empty  = 1'b0;
        r.status = st;
        dump_expect.push_back(r);
      end
    end
  endtask

  // Queue one operation, tracking the list length the way the block would.
  task automatic queue_op(input op_e op, input logic signed [VALUE_W-1:0] val,
                          input logic [POS_W-1:0] pos, input int unsigned phase,
                          input bit hold, inout int unsigned len);
    list_op_t item;
    item = '{op: op, value: val, position: pos, phase: phase, hold: hold};
    op_backlog.push_back(item);
    if (op == OP_APPEND) begin
      if (len < ListDepth) len++;
    end else if (pos < len) begin
      len--;
    end
  endtask

  // Random value with the extremes drawn now and then.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Build the stimulus: a directed run first, then biased random runs.
  initial begin
    int unsigned len;
    int unsigned append_pct;
    int unsigned phase;
    bit          hold;
    op_e         op;
    logic [POS_W-1:0] pos;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = 1'b0;
    value_i     = '0;
    position_i  = '0;
    out_ready_i = 1'b0;
    in_taken    = 1'b0;
    error_count = 0;
    send_idle_pct = 29;
    recv_idle_pct = 57;
    len = 0;
    append_pct = 55;

    // Removal from an empty list at both ends of the position range.
    queue_op(OP_REMOVE, '1, 4'd0, 0, 1'b0, len);
    queue_op(OP_REMOVE, '0, 4'd15, 0, 1'b0, len);
    // Fill to capacity, starting with the value extremes.
    queue_op(OP_APPEND, {1'b1, {(VALUE_W-1){1'b0}}}, 4'd15, 0, 1'b0, len);
    queue_op(OP_APPEND, {1'b0, {(VALUE_W-1){1'b1}}}, 4'd0, 0, 1'b0, len);
    queue_op(OP_APPEND, '0, 4'd5, 0, 1'b0, len);
    queue_op(OP_APPEND, '1, 4'd10, 0, 1'b0, len);
    queue_op(OP_APPEND, 32'sh5555_5555, 4'd0, 0, 1'b0, len);
    queue_op(OP_APPEND, 32'shAAAA_AAAA, 4'd15, 0, 1'b0, len);
    for (int i = 6; i < ListDepth; i++) begin
      queue_op(OP_APPEND, $urandom, POS_W'($urandom), 0, 1'b0, len);
    end
    // Append to a full list is dropped.
    queue_op(OP_APPEND, 32'sh1234_5678, 4'd3, 0, 1'b0, len);
    // Remove the tail, then the head, then past the end, then the middle.
    queue_op(OP_REMOVE, '0, 4'd15, 0, 1'b0, len);
    queue_op(OP_REMOVE, '1, 4'd0, 0, 1'b0, len);
    queue_op(OP_REMOVE, '0, 4'd14, 0, 1'b0, len);
    queue_op(OP_REMOVE, '0, 4'd5, 0, 1'b0, len);

    // Random runs in segments that push the list towards full or empty.
    for (int unsigned n = 0; n < RandomOps; n++) begin
      if (n % 20 == 0) begin
        case ($urandom_range(2))
          0:       append_pct = 85;
          1:       append_pct = 20;
          default: append_pct = 55;
        endcase
      end
      phase = (n < 140) ? 0 : (n < 300) ? 1 : 2;
      hold  = (n == 60) || (n == 200) || (n == 380);
      if ($urandom_range(99) < append_pct) begin
        op  = OP_APPEND;
        pos = POS_W'($urandom);
      end else begin
        op = OP_REMOVE;
        if (len > 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(len - 1));
        else pos = POS_W'($urandom);
      end
      queue_op(op, pick_value(), pos, phase, hold, len);
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every operation to be taken and every dump to drain.
    while (op_backlog.size() != 0 || in_valid_i) @(negedge clk_i);
    while (dump_expect.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: presents operations and the output ready at the falling edge.
  always @(negedge clk_i) begin
    list_op_t item;
    bit       free;
    if (rst_ni) begin
      free = !in_valid_i || in_taken;
      if (free) begin
        if (op_backlog.size() != 0 &&
            (!op_backlog[0].hold || dump_expect.size() == 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          item = op_backlog.pop_front();
          case (item.phase)
            0:       begin send_idle_pct = 29; recv_idle_pct = 57; end
            1:       begin send_idle_pct = 57; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
          endcase
          in_valid_i <= 1'b1;
          mode_i     <= logic'(item.op);
          value_i    <= item.value;
          position_i <= item.position;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin
    res_t exp_r;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_dump(op_e'(mode_i), value_i, position_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (dump_expect.size() == 0) begin
          $error("result transfer with no dump outstanding: value %0d index %0d",
                 entry_value_o, entry_index_o);
          error_count++;
        end else begin
          exp_r = dump_expect.pop_front();
          if (entry_value_o !== exp_r.value) begin
            $error("entry_value: expected %0d, got %0d", exp_r.value, entry_value_o);
            error_count++;
          end
          if (entry_index_o !== exp_r.index) begin
            $error("entry_index: expected %0d, got %0d", exp_r.index, entry_index_o);
            error_count++;
          end
          if (last_entry_o !== exp_r.last) begin
            $error("last_entry: expected %0b, got %0b", exp_r.last, last_entry_o);
            error_count++;
          end
          if (list_empty_o !== exp_r.empty) begin
            $error("list_empty: expected %0b, got %0b", exp_r.empty, list_empty_o);
            error_count++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> ordered_list_append_remove_unit.f
rtl/olar_pkg.sv
rtl/olar_ram.sv
rtl/olar_front.sv
rtl/olar_back.sv
rtl/ordered_list_append_remove_unit.sv
rtl/olar_checker.sv
verif/ordered_list_append_remove_unit_test.sv
